// ----- design/kscu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword substitution cipher package
// Shared constants and the table port bundle of the cipher unit.
// ----------------------------------------------------------------------------
package kscu_pkg;

  localparam int unsigned LETTERS  = 26;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CHAR_W   = 8;

  localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;
  localparam logic [CHAR_W-1:0]   ASCII_A     = 8'd65;
  localparam logic [CHAR_W-1:0]   ASCII_Z     = 8'd90;
  localparam logic [LETTERS-1:0]  ALL_USED    = {LETTERS{1'b1}};

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LETTER  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ENCRYPT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DECRYPT = 3'd4;

  // One access to a table memory: a write port and a read port.
  typedef struct packed {
    logic                wr_en;
    logic [LETTER_W-1:0] wr_addr;
    logic [LETTER_W-1:0] wr_data;
    logic                rd_en;
    logic [LETTER_W-1:0] rd_addr;
  } table_req_t;

endpackage

// ----- design/kscu_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cipher table memory
// 26 x 5 synchronous memory with one write and one registered read port.
// Until the first key is started, reads return the reversed alphabet.
// ----------------------------------------------------------------------------
module kscu_table (
  input  logic                             clk,
  input  logic                             loaded,
  input  kscu_pkg::table_req_t             req,
  output logic [kscu_pkg::LETTER_W-1:0]    rd_data
);

  logic [kscu_pkg::LETTER_W-1:0] mem [kscu_pkg::LETTERS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Entries are only read while a key is complete, so after the first clear
  // every entry has been written before it is read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (loaded) begin
        rd_data <= mem[req.rd_addr];
      end else begin
        rd_data <= kscu_pkg::LAST_LETTER - req.rd_addr;
      end
    end
  end

endmodule

// ----- design/keyword_substitution_cipher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword substitution cipher unit
// Builds a keyword cipher alphabet and encrypts or decrypts A-Z letters.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one command per transfer: s_tuser carries the
//   command (clear, key letter, finish, encrypt, decrypt) and s_tdata the
//   ASCII byte. The master channel returns one ASCII letter per encrypt or
//   decrypt of an uppercase letter while the key is complete; every other
//   command produces no transfer.
//   Clear, key letter and ignored commands are completed on acceptance. Encrypt
//   and decrypt first read the table memory, then load the output register
//   from the LOOKUP state once that register is free.
//   Finish walks the 26 letters from Z down to A, one letter per cycle,
//   with a memory write pair per unused letter, and holds s_tready low meanwhile.
//   After reset the reversed alphabet Z..A is the active key.
//   When the receiver stalls, the result waits in the output register;
//   commands that need no output keep being accepted, and a new lookup is
//   accepted but held until the output register frees up.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kscu_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_in
  input  logic [kscu_pkg::CMD_W-1:0]    s_tuser,   // [2:0] cmd
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [kscu_pkg::CHAR_W-1:0]   m_tdata    // [7:0] char_out
);

  typedef enum logic [1:0] {
    IDLE,
    LOOKUP,
    FINISH
  } state_t;

  state_t                          state;
  logic [kscu_pkg::LETTERS-1:0]    used_letters;
  logic [kscu_pkg::LETTER_W-1:0]   key_length;
  logic                            key_ready;
  logic                            loaded;     // set once the first key is started
  logic [kscu_pkg::LETTER_W-1:0]   scan;       // letter under test during finish
  logic                            use_inverse;

  kscu_pkg::table_req_t            fwd_req;
  kscu_pkg::table_req_t            inv_req;
  logic [kscu_pkg::LETTER_W-1:0]   fwd_data;
  logic [kscu_pkg::LETTER_W-1:0]   inv_data;

  logic                            accept;
  logic                            is_upper;
  logic [kscu_pkg::CHAR_W-1:0]     char_off;
  logic [kscu_pkg::LETTER_W-1:0]   letter;
  logic                            place_key;
  logic                            place_scan;
  logic                            lookup;
  logic                            out_free;
  logic [kscu_pkg::LETTER_W-1:0]   result;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_upper = (s_tdata >= kscu_pkg::ASCII_A) && (s_tdata <= kscu_pkg::ASCII_Z);
  assign char_off = s_tdata - kscu_pkg::ASCII_A;
  assign letter   = char_off[kscu_pkg::LETTER_W-1:0];
  assign out_free = !m_tvalid || m_tready;

  // A key letter is placed only if it is new and the key still has room.
  assign place_key = accept && (s_tuser == kscu_pkg::CMD_LETTER) && !key_ready && is_upper
                     && !used_letters[letter]
                     && (key_length < kscu_pkg::LETTER_W'(kscu_pkg::LETTERS));

  assign place_scan = (state == FINISH) && !used_letters[scan]
                      && (key_length < kscu_pkg::LETTER_W'(kscu_pkg::LETTERS));

  assign lookup = accept && key_ready && is_upper
                  && ((s_tuser == kscu_pkg::CMD_ENCRYPT) || (s_tuser == kscu_pkg::CMD_DECRYPT));

  // Forward table: position -> letter. Inverse table: letter -> position.
  always_comb begin
    fwd_req.wr_en   = place_key || place_scan;
    fwd_req.wr_addr = key_length;
    fwd_req.wr_data = place_scan ? scan : letter;
    fwd_req.rd_en   = lookup && (s_tuser == kscu_pkg::CMD_ENCRYPT);
    fwd_req.rd_addr = letter;

    inv_req.wr_en   = place_key || place_scan;
    inv_req.wr_addr = place_scan ? scan : letter;
    inv_req.wr_data = key_length;
    inv_req.rd_en   = lookup && (s_tuser == kscu_pkg::CMD_DECRYPT);
    inv_req.rd_addr = letter;
  end

  kscu_table u_fwd_table (
    .clk     (clk),
    .loaded  (loaded),
    .req     (fwd_req),
    .rd_data (fwd_data)
  );

  kscu_table u_inv_table (
    .clk     (clk),
    .loaded  (loaded),
    .req     (inv_req),
    .rd_data (inv_data)
  );

  assign result = use_inverse ? inv_data : fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      used_letters <= kscu_pkg::ALL_USED;
      key_length   <= '0;
      key_ready    <= 1'b1;
      loaded       <= 1'b0;
      scan         <= kscu_pkg::LAST_LETTER;
      use_inverse  <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // In LOOKUP the output register is either reloaded below or still
      // stalled, so the drain is handled here only in the other states.
      if (m_tvalid && m_tready && (state != LOOKUP)) begin
        m_tvalid <= 1'b0;
      end

      if (place_key || place_scan) begin
        key_length <= key_length + 1'b1;
      end
      if (place_key) begin
        used_letters[letter] <= 1'b1;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            if (s_tuser == kscu_pkg::CMD_CLEAR) begin
              used_letters <= '0;
              key_length   <= '0;
              key_ready    <= 1'b0;
              loaded       <= 1'b1;
            end else if ((s_tuser == kscu_pkg::CMD_FINISH) && !key_ready) begin
              scan  <= kscu_pkg::LAST_LETTER;
              state <= FINISH;
            end else if (lookup) begin
              use_inverse <= (s_tuser == kscu_pkg::CMD_DECRYPT);
              state       <= LOOKUP;
            end
          end
        end
        LOOKUP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= kscu_pkg::ASCII_A + kscu_pkg::CHAR_W'(result);
            state    <= IDLE;
          end
        end
        FINISH: begin
          if (scan == '0) begin
            used_letters <= kscu_pkg::ALL_USED;
            key_ready    <= 1'b1;
            state        <= IDLE;
          end else begin
            scan <= scan - 1'b1;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
